/* rtl/bbrs_pkg.sv */
// ----------------------------------------------------------------------------
// bbrs_pkg
// Shared types and constants of the bad-block remap store.
// ----------------------------------------------------------------------------
package bbrs_pkg;

    localparam int NUM_BLOCKS_DEF = 128;
    localparam int NUM_SPARES_DEF = 16;

    localparam int CMD_W    = 2;
    localparam int BLOCK_W  = 7;
    localparam int LEN_W    = 7;
    localparam int TAG_W    = 8;
    localparam int STATUS_W = 2;
    localparam int ADDR_W   = 8;

    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 24;

    localparam logic [LEN_W-1:0] MAX_RUN = 7'd64;

    localparam logic [CMD_W-1:0] CMD_MARK  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_SPARE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BEYOND   = 2'd2;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_MARK,
        S_LOOK,
        S_ACC,
        S_RDATA,
        S_ACK
    } t_state;

    typedef struct packed {
        logic load;
        logic clr_step;
        logic look;
        logic acc_wr;
        logic emit_mark;
        logic emit_read;
        logic emit_ack;
        logic next;
    } t_dp_cmd;

    typedef struct packed {
        logic             clr_done;
        logic             out_free;
        logic             run_done;
        logic             last_blk;
        logic             beyond;
        logic [CMD_W-1:0] cmd;
    } t_dp_stat;

endpackage

/* rtl/bbrs_ram.sv */
// ----------------------------------------------------------------------------
// bbrs_ram
// Generic single-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module bbrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/bbrs_datapath.sv */
// ----------------------------------------------------------------------------
// bbrs_datapath
// Remap table, block store, run counters and the result register.
// ----------------------------------------------------------------------------
module bbrs_datapath #(
    parameter int NUM_BLOCKS = bbrs_pkg::NUM_BLOCKS_DEF,
    parameter int NUM_SPARES = bbrs_pkg::NUM_SPARES_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  bbrs_pkg::t_dp_cmd                  i_cmd,
    output bbrs_pkg::t_dp_stat                 o_stat,
    input  logic [bbrs_pkg::IN_TDATA_W-1:0]    i_s_tdata,
    input  logic [bbrs_pkg::CMD_W-1:0]         i_s_tuser,
    input  logic                               i_m_tready,
    output logic                               o_m_tvalid,
    output logic [bbrs_pkg::OUT_TDATA_W-1:0]   o_m_tdata,
    output logic [bbrs_pkg::STATUS_W-1:0]      o_m_tuser,
    output logic                               o_m_tlast
);

    localparam int AW         = $clog2(NUM_BLOCKS);
    localparam int SW         = $clog2(NUM_SPARES + 1);
    localparam int TIW        = (NUM_SPARES > 1) ? $clog2(NUM_SPARES) : 1;
    localparam int SPARE_BASE = (NUM_BLOCKS > NUM_SPARES) ? (NUM_BLOCKS - NUM_SPARES) : 0;
    localparam int CW         = 9;

    logic [bbrs_pkg::CMD_W-1:0]    r_cmd;
    logic [bbrs_pkg::BLOCK_W-1:0]  r_first;
    logic [bbrs_pkg::LEN_W-1:0]    r_len;
    logic [bbrs_pkg::TAG_W-1:0]    r_tag;
    logic [bbrs_pkg::LEN_W-1:0]    r_cnt;
    logic [bbrs_pkg::ADDR_W-1:0]   r_lb;
    logic                          r_skip;
    logic [AW-1:0]                 r_hit_pb;
    logic                          r_lb_ok;
    logic [bbrs_pkg::ADDR_W-1:0]   r_pb0;
    logic [bbrs_pkg::BLOCK_W-1:0]  r_table [NUM_SPARES];
    logic [SW-1:0]                 r_used;
    logic [AW-1:0]                 r_clr;

    logic                          r_out_valid;
    logic [bbrs_pkg::STATUS_W-1:0] r_out_status;
    logic [bbrs_pkg::ADDR_W-1:0]   r_out_lb;
    logic [bbrs_pkg::ADDR_W-1:0]   r_out_pb;
    logic [bbrs_pkg::TAG_W-1:0]    r_out_rd;
    logic                          r_out_last;

    logic [bbrs_pkg::BLOCK_W-1:0]  in_first;
    logic [bbrs_pkg::LEN_W-1:0]    in_len;
    logic [bbrs_pkg::TAG_W-1:0]    in_tag;
    logic                          hit_any;
    logic [TIW-1:0]                hit_idx;
    logic [AW-1:0]                 look_pb;
    logic                          lb_beyond;
    logic                          first_beyond;
    logic [CW-1:0]                 spare;
    logic                          no_spare;
    logic                          out_free;
    logic                          ram_we;
    logic [AW-1:0]                 ram_addr;
    logic [bbrs_pkg::TAG_W-1:0]    ram_wdata;
    logic [bbrs_pkg::TAG_W-1:0]    ram_rdata;

    assign in_first = i_s_tdata[bbrs_pkg::BLOCK_W-1:0];
    assign in_len   = i_s_tdata[bbrs_pkg::BLOCK_W +: bbrs_pkg::LEN_W];
    assign in_tag   = i_s_tdata[bbrs_pkg::BLOCK_W + bbrs_pkg::LEN_W +: bbrs_pkg::TAG_W];

    // The lowest matching table entry wins.
    always_comb begin
        hit_any = 1'b0;
        hit_idx = '0;
        for (int k = NUM_SPARES - 1; k >= 0; k--) begin
            if ((k < int'(r_used)) && ({1'b0, r_table[k]} == r_lb)) begin
                hit_any = 1'b1;
                hit_idx = TIW'(k);
            end
        end
    end

    assign look_pb      = hit_any ? (AW'(SPARE_BASE) + AW'(hit_idx)) : r_lb[AW-1:0];
    assign lb_beyond    = ({1'b0, r_lb} >= CW'(NUM_BLOCKS));
    assign first_beyond = ({2'b0, r_first} >= CW'(NUM_BLOCKS));
    assign spare        = CW'(SPARE_BASE) + CW'(r_used);
    assign no_spare     = (int'(r_used) >= NUM_SPARES) || (spare >= CW'(NUM_BLOCKS));
    assign out_free     = !r_out_valid || i_m_tready;

    assign ram_we    = i_cmd.clr_step || i_cmd.acc_wr;
    assign ram_addr  = i_cmd.clr_step ? r_clr : r_hit_pb;
    assign ram_wdata = i_cmd.clr_step ? '0 : r_tag;

    bbrs_ram #(
        .WIDTH (bbrs_pkg::TAG_W),
        .DEPTH (NUM_BLOCKS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used      <= '0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr_step) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cmd.emit_mark && !first_beyond && !no_spare) begin
                r_used <= r_used + 1'b1;
            end
            if (i_cmd.emit_mark || i_cmd.emit_read || i_cmd.emit_ack) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd   <= i_s_tuser;
            r_first <= in_first;
            r_len   <= (in_len > bbrs_pkg::MAX_RUN) ? bbrs_pkg::MAX_RUN : in_len;
            r_tag   <= in_tag;
            r_cnt   <= '0;
            r_lb    <= {1'b0, in_first};
            r_skip  <= 1'b0;
        end
        if (i_cmd.look) begin
            r_hit_pb <= look_pb;
            r_lb_ok  <= !lb_beyond;
            if (r_cnt == '0) begin
                r_pb0 <= lb_beyond ? '0 : bbrs_pkg::ADDR_W'(look_pb);
            end
            if ((r_cnt != r_len) && lb_beyond) begin
                r_skip <= 1'b1;
            end
        end
        if (i_cmd.next) begin
            r_cnt <= r_cnt + 1'b1;
            r_lb  <= r_lb + 1'b1;
        end
        if (i_cmd.emit_mark && !first_beyond && !no_spare) begin
            r_table[r_used[TIW-1:0]] <= r_first;
        end
        if (i_cmd.emit_mark) begin
            r_out_lb   <= {1'b0, r_first};
            r_out_rd   <= '0;
            r_out_last <= 1'b1;
            if (first_beyond) begin
                r_out_status <= bbrs_pkg::ST_BEYOND;
                r_out_pb     <= '0;
            end else if (no_spare) begin
                r_out_status <= bbrs_pkg::ST_NO_SPARE;
                r_out_pb     <= '0;
            end else begin
                r_out_status <= bbrs_pkg::ST_OK;
                r_out_pb     <= spare[bbrs_pkg::ADDR_W-1:0];
            end
        end
        if (i_cmd.emit_read) begin
            r_out_status <= r_lb_ok ? bbrs_pkg::ST_OK : bbrs_pkg::ST_BEYOND;
            r_out_lb     <= r_lb;
            r_out_pb     <= r_lb_ok ? bbrs_pkg::ADDR_W'(r_hit_pb) : '0;
            r_out_rd     <= r_lb_ok ? ram_rdata : '0;
            r_out_last   <= (r_cnt + 1'b1 == r_len);
        end
        if (i_cmd.emit_ack) begin
            r_out_status <= r_skip ? bbrs_pkg::ST_BEYOND : bbrs_pkg::ST_OK;
            r_out_lb     <= {1'b0, r_first};
            r_out_pb     <= r_pb0;
            r_out_rd     <= '0;
            r_out_last   <= 1'b1;
        end
    end

    assign o_stat.clr_done = (r_clr == AW'(NUM_BLOCKS - 1));
    assign o_stat.out_free = out_free;
    assign o_stat.run_done = (r_cnt == r_len);
    assign o_stat.last_blk = (r_cnt + 1'b1 == r_len);
    assign o_stat.beyond   = lb_beyond;
    assign o_stat.cmd      = r_cmd;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_rd, r_out_pb, r_out_lb};
    assign o_m_tuser  = r_out_status;
    assign o_m_tlast  = r_out_last;

endmodule

/* rtl/bbrs_ctrl.sv */
// ----------------------------------------------------------------------------
// bbrs_ctrl
// Sequencer for store clearing, marks and block runs.
// ----------------------------------------------------------------------------
module bbrs_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    input  bbrs_pkg::t_dp_stat i_stat,
    output bbrs_pkg::t_dp_cmd  o_cmd
);

    bbrs_pkg::t_state r_state;
    bbrs_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bbrs_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        case (r_state)
            bbrs_pkg::S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_done) begin
                    n_state = bbrs_pkg::S_IDLE;
                end
            end
            bbrs_pkg::S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = bbrs_pkg::S_DISPATCH;
                end
            end
            bbrs_pkg::S_DISPATCH: begin
                case (i_stat.cmd)
                    bbrs_pkg::CMD_MARK:  n_state = bbrs_pkg::S_MARK;
                    bbrs_pkg::CMD_WRITE: n_state = bbrs_pkg::S_LOOK;
                    bbrs_pkg::CMD_READ: begin
                        n_state = i_stat.run_done ? bbrs_pkg::S_IDLE : bbrs_pkg::S_LOOK;
                    end
                    default: n_state = bbrs_pkg::S_IDLE;
                endcase
            end
            bbrs_pkg::S_MARK: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_mark = 1'b1;
                    n_state         = bbrs_pkg::S_IDLE;
                end
            end
            bbrs_pkg::S_LOOK: begin
                o_cmd.look = 1'b1;
                if (i_stat.cmd == bbrs_pkg::CMD_WRITE) begin
                    if (i_stat.run_done || i_stat.beyond) begin
                        n_state = bbrs_pkg::S_ACK;
                    end else begin
                        n_state = bbrs_pkg::S_ACC;
                    end
                end else begin
                    n_state = i_stat.beyond ? bbrs_pkg::S_RDATA : bbrs_pkg::S_ACC;
                end
            end
            bbrs_pkg::S_ACC: begin
                if (i_stat.cmd == bbrs_pkg::CMD_WRITE) begin
                    o_cmd.acc_wr = 1'b1;
                    o_cmd.next   = 1'b1;
                    n_state      = bbrs_pkg::S_LOOK;
                end else begin
                    n_state = bbrs_pkg::S_RDATA;
                end
            end
            bbrs_pkg::S_RDATA: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_read = 1'b1;
                    o_cmd.next      = 1'b1;
                    n_state = i_stat.last_blk ? bbrs_pkg::S_IDLE : bbrs_pkg::S_LOOK;
                end
            end
            bbrs_pkg::S_ACK: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_ack = 1'b1;
                    n_state        = bbrs_pkg::S_IDLE;
                end
            end
            default: n_state = bbrs_pkg::S_IDLE;
        endcase
    end

endmodule

/* rtl/bad_block_remap_store.sv */
// ----------------------------------------------------------------------------
// bad_block_remap_store
// Block store with bad-block sparing through a first-match remap table.
//
// Channel   Direction  tdata (low bit up)                            tuser    tlast
// s_axis    in         first_block[6:0] run_length[13:7] tag[21:14]  cmd      -
// m_axis    out        logical[7:0] physical[15:8] read_data[23:16]  status   last
//
// After reset every store entry is cleared while s_axis is held off.
// A mark passes through dispatch and emits its word; a write run looks up and
// stores each block, then emits one ack word; a read run looks up each block and
// reads the store (a block beyond range skips the read). One word is taken at a time; a
// stalled m_axis holds the sequencer at its next result word.
// ----------------------------------------------------------------------------
module bad_block_remap_store #(
    parameter int NUM_BLOCKS = bbrs_pkg::NUM_BLOCKS_DEF,
    parameter int NUM_SPARES = bbrs_pkg::NUM_SPARES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // first_block[6:0], run_length[13:7], tag_value[21:14], zero pad
    input  logic [bbrs_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    // cmd[1:0]
    input  logic [bbrs_pkg::CMD_W-1:0]       i_s_axis_tuser,
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // logical_block[7:0], physical_block[15:8], read_data[23:16]
    output logic [bbrs_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    // status[1:0]
    output logic [bbrs_pkg::STATUS_W-1:0]    o_m_axis_tuser,
    output logic                             o_m_axis_tlast
);

    bbrs_pkg::t_dp_cmd  dp_cmd;
    bbrs_pkg::t_dp_stat dp_stat;

    bbrs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .o_s_tready (o_s_axis_tready),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    bbrs_datapath #(
        .NUM_BLOCKS (NUM_BLOCKS),
        .NUM_SPARES (NUM_SPARES)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (dp_cmd),
        .o_stat     (dp_stat),
        .i_s_tdata  (i_s_axis_tdata),
        .i_s_tuser  (i_s_axis_tuser),
        .i_m_tready (i_m_axis_tready),
        .o_m_tvalid (o_m_axis_tvalid),
        .o_m_tdata  (o_m_axis_tdata),
        .o_m_tuser  (o_m_axis_tuser),
        .o_m_tlast  (o_m_axis_tlast)
    );

endmodule
